// ===== hw/rtl/plirls_pkg.sv =====
// ----------------------------------------------------------------------------
// plirls_pkg
// Shared types, constants and codes of the Poisson log-link IRLS step core.
// ----------------------------------------------------------------------------
package plirls_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int NUM_COEF     = 6;
	localparam int NUM_REGS     = 8;
	localparam int MAX_OBS      = 1048576;
	localparam int CNT_W        = 21;
	localparam int TAYLOR_TERMS = 13;
	localparam int LOG_ITERS    = 30;
	localparam int DIV_STEPS    = 64;
	localparam int STEP_W       = 6;

	localparam logic [30:0] LN2_Q30   = 31'd744261118;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

	// mean used for a zero count in start mode: round(0.01 * 2^F)
	localparam logic [31:0] ZERO_MEAN = 32'((2 ** FRAC_BITS + 50) / 100);

	// floor(2^32 / k) for k = 1..13; k = 1 uses 2^32-1 and relies on the fixup
	localparam logic [31:0] RECIP [16] = '{
		32'd0,          32'd4294967295, 32'd2147483648, 32'd1431655765,
		32'd1073741824, 32'd858993459,  32'd715827882,  32'd613566756,
		32'd536870912,  32'd477218588,  32'd429496729,  32'd390451572,
		32'd357913941,  32'd330382099,  32'd0,          32'd0
	};

	// register indexes
	localparam logic [2:0] REG_MODEL_RANK = 3'd6;
	localparam logic [2:0] REG_START_MODE = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SAT_HIGH  = 2'd1;
	localparam logic [1:0] ST_CLAMP_LOW = 2'd2;
	localparam logic [1:0] ST_FEW_ITEMS = 2'd3;

	typedef struct packed {
		logic signed [31:0] x_0;
		logic signed [31:0] x_1;
		logic signed [31:0] x_2;
		logic signed [31:0] x_3;
		logic signed [31:0] x_4;
		logic signed [31:0] x_5;
		logic [15:0]        count;
		logic signed [31:0] offset;
		logic               last_obs;
	} obs_item_t;

	typedef struct packed {
		logic [31:0]        mean;
		logic signed [31:0] working_response;
		logic [47:0]        dispersion;
		logic               dispersion_valid;
		logic [1:0]         status;
		logic               last_result;
	} res_item_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_DOT, OP_EXP_T, OP_EXP_U, OP_TAY_MUL, OP_TAY_EST,
		OP_TAY_FIX, OP_EXP_FIN, OP_LOG_NORM, OP_LOG_SQ, OP_LOG_MUL, OP_DIVQ_INIT,
		OP_DIV_STEP, OP_RESP, OP_PSQ, OP_ACC, OP_DIVD_INIT, OP_DISP, OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DOT, S_EXP_T, S_EXP_U, S_TAY_MUL, S_TAY_EST, S_TAY_FIX,
		S_EXP_FIN, S_LOG_NORM, S_LOG_SQ, S_LOG_MUL, S_DIVQ_INIT, S_DIVQ,
		S_RESP, S_PSQ, S_DIVP, S_ACC, S_CHK, S_DIVD, S_DISP, S_OUT
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [STEP_W-1:0] step;
	} ctl_cmd_t;

	typedef struct packed {
		logic start;
		logic need_disp;
	} dp_sts_t;

endpackage

// ===== hw/rtl/plirls_if.sv =====
// ----------------------------------------------------------------------------
// plirls channel interfaces
// Valid/ready channels for observations, results and register writes.
// ----------------------------------------------------------------------------
interface plirls_obs_if
	import plirls_pkg::*;
();
	logic      valid;
	logic      ready;
	obs_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface plirls_res_if
	import plirls_pkg::*;
();
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface plirls_cfg_if
	import plirls_pkg::*;
();
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/poisson_log_link_irls_step_core.sv =====
// ----------------------------------------------------------------------------
// poisson_log_link_irls_step_core
// One Poisson log-link IRLS pass over a stream of observations, Q16.16.
// ----------------------------------------------------------------------------
// Each observation transfer yields exactly one result transfer carrying the
// fitted mean (also the IRLS weight), the working response and a status; on
// the observation marked last_obs the result also carries the Pearson
// dispersion when the pass holds more items than the model rank, and the
// running sum and item count clear. One observation is in flight at a time.
// Each runs through the shared radix-2 divider (64 steps for count/mean, 64
// for the Pearson term, 64 for the dispersion, the last only on a last
// observation that yields a dispersion), the 30-step squaring log2 loop and,
// in fitted mode only, the 13-term exp series with a multiply, an estimate
// and a fix step per term. A new observation transfers as soon as the
// previous one has reached the result register, even while that result
// still waits for its transfer. Register writes are taken in any cycle and
// must only be issued while the core is idle. There is no clearing pass.
// ----------------------------------------------------------------------------
module poisson_log_link_irls_step_core
	import plirls_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	plirls_obs_if.sink  obs,
	plirls_res_if.source res,
	plirls_cfg_if.sink  cfg
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;
	logic     cfg_we;

	// register writes never stall
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid;

	// sequencer: owns obs.ready and res.valid, drives one command a cycle
	plirls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.obs_valid (obs.valid),
		.obs_ready (obs.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: holds the registers, arithmetic units and the result register
	plirls_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.obs_data  (obs.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.res_data  (res.data)
	);

endmodule

// ===== hw/rtl/plirls_ctrl.sv =====
// ----------------------------------------------------------------------------
// plirls_ctrl
// Sequencer: steps the datapath through one observation and owns the
// handshake state of both item channels.
// ----------------------------------------------------------------------------
module plirls_ctrl
	import plirls_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     obs_valid,
	output logic     obs_ready,
	output logic     res_valid,
	input  logic     res_ready,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic              res_valid_q;
	logic              slot_free;

	assign slot_free = !res_valid_q || res_ready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				cnt_d = '0;
				if (obs_valid) state_d = S_DOT;
			end
			S_DOT: begin
				if (sts.start) begin
					state_d = S_LOG_NORM;
				end else if (cnt_q == STEP_W'(NUM_COEF - 1)) begin
					cnt_d   = '0;
					state_d = S_EXP_T;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_EXP_T:   state_d = S_EXP_U;
			S_EXP_U:   state_d = S_TAY_MUL;
			S_TAY_MUL: state_d = S_TAY_EST;
			S_TAY_EST: state_d = S_TAY_FIX;
			S_TAY_FIX: begin
				if (cnt_q == STEP_W'(TAYLOR_TERMS - 1)) begin
					cnt_d   = '0;
					state_d = S_EXP_FIN;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = S_TAY_MUL;
				end
			end
			S_EXP_FIN:  state_d = S_LOG_NORM;
			S_LOG_NORM: begin
				cnt_d   = '0;
				state_d = S_LOG_SQ;
			end
			S_LOG_SQ: begin
				if (cnt_q == STEP_W'(LOG_ITERS - 1)) begin
					cnt_d   = '0;
					state_d = S_LOG_MUL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_LOG_MUL:   state_d = S_DIVQ_INIT;
			S_DIVQ_INIT: state_d = S_DIVQ;
			S_DIVQ: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) state_d = S_RESP;
			end
			S_RESP: state_d = S_PSQ;
			S_PSQ:  state_d = S_DIVP;
			S_DIVP: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) state_d = S_ACC;
			end
			S_ACC: state_d = S_CHK;
			S_CHK: begin
				cnt_d   = '0;
				state_d = sts.need_disp ? S_DIVD : S_OUT;
			end
			S_DIVD: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) state_d = S_DISP;
			end
			S_DISP: state_d = S_OUT;
			S_OUT: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = OP_NONE;
		cmd.step  = cnt_q;
		obs_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				obs_ready = 1'b1;
				if (obs_valid) cmd.op = OP_LOAD;
			end
			S_DOT:       cmd.op = sts.start ? OP_NONE : OP_DOT;
			S_EXP_T:     cmd.op = OP_EXP_T;
			S_EXP_U:     cmd.op = OP_EXP_U;
			S_TAY_MUL:   cmd.op = OP_TAY_MUL;
			S_TAY_EST:   cmd.op = OP_TAY_EST;
			S_TAY_FIX:   cmd.op = OP_TAY_FIX;
			S_EXP_FIN:   cmd.op = OP_EXP_FIN;
			S_LOG_NORM:  cmd.op = OP_LOG_NORM;
			S_LOG_SQ:    cmd.op = OP_LOG_SQ;
			S_LOG_MUL:   cmd.op = OP_LOG_MUL;
			S_DIVQ_INIT: cmd.op = OP_DIVQ_INIT;
			S_DIVQ:      cmd.op = OP_DIV_STEP;
			S_RESP:      cmd.op = OP_RESP;
			S_PSQ:       cmd.op = OP_PSQ;
			S_DIVP:      cmd.op = OP_DIV_STEP;
			S_ACC:       cmd.op = OP_ACC;
			S_CHK:       cmd.op = sts.need_disp ? OP_DIVD_INIT : OP_NONE;
			S_DIVD:      cmd.op = OP_DIV_STEP;
			S_DISP:      cmd.op = OP_DISP;
			S_OUT:       cmd.op = slot_free ? OP_OUT : OP_NONE;
			default:     cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.op == OP_OUT) res_valid_q <= 1'b1;
			else if (res_ready)   res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

`ifndef SYNTH
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		obs_valid && obs_ready |=> state_q == S_DOT)
		else $error("accepted item did not start the dot product");
	a_taylor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAY_FIX |-> cnt_q < STEP_W'(TAYLOR_TERMS))
		else $error("Taylor term index out of range");
	a_log_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOG_SQ |-> cnt_q < STEP_W'(LOG_ITERS))
		else $error("log iteration index out of range");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> (!res_valid_q || res_ready))
		else $error("result register loaded while still full");
`endif

endmodule

// ===== hw/rtl/plirls_dp.sv =====
// ----------------------------------------------------------------------------
// plirls_dp
// Datapath: registers, dot product, exp and log units, shared radix-2
// divider, Pearson accumulator and result register.
// ----------------------------------------------------------------------------
module plirls_dp
	import plirls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    cmd,
	output dp_sts_t     sts,
	input  obs_item_t   obs_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output res_item_t   res_data
);

	// configuration
	logic signed [31:0] coef_q [NUM_COEF];
	logic [2:0]         rank_q;
	logic               start_q;

	// pass state
	logic [63:0]      rsum_q;
	logic [CNT_W-1:0] obs_cnt_q;

	// working registers
	obs_item_t          item_q;
	logic signed [50:0] eta_q;
	logic signed [53:0] t_q;
	logic [29:0]        u_q;
	logic [30:0]        term_q;
	logic [30:0]        x_q;
	logic [30:0]        est_q;
	logic [31:0]        sum_q;
	logic [31:0]        mean_q;
	logic [1:0]         mst_q;
	logic [30:0]        m_q;
	logic [29:0]        frac_q;
	logic [4:0]         e_q;
	logic signed [60:0] lp_q;
	logic [31:0]        rem_q;
	logic [63:0]        dvd_q;
	logic [31:0]        dvs_q;
	logic signed [31:0] z_q;
	logic [31:0]        d_q;
	logic [47:0]        disp_q;
	logic               disp_v_q;
	res_item_t          res_q;

	logic signed [31:0] row [NUM_COEF];
	assign row[0] = item_q.x_0;
	assign row[1] = item_q.x_1;
	assign row[2] = item_q.x_2;
	assign row[3] = item_q.x_3;
	assign row[4] = item_q.x_4;
	assign row[5] = item_q.x_5;

	logic few;
	assign few           = obs_cnt_q <= CNT_W'(rank_q);
	assign sts.start     = start_q;
	assign sts.need_disp = item_q.last_obs && !few;

	// dot product term, floored to Q.F
	logic signed [63:0] dprod;
	logic signed [50:0] eta_next;
	always_comb begin
		dprod    = row[cmd.step[2:0]] * coef_q[cmd.step[2:0]];
		eta_next = eta_q + 51'(dprod >>> FRAC_BITS);
	end

	// clamp eta to +-32 and scale by log2(e)
	logic signed [22:0] eta_c;
	always_comb begin
		if (eta_q > 51'sd2097152)       eta_c = 23'sd2097152;
		else if (eta_q < -51'sd2097152) eta_c = -23'sd2097152;
		else                            eta_c = 23'(eta_q);
	end

	// Taylor step helpers
	logic [60:0] tprod;
	logic [62:0] rprod;
	logic [3:0]  k;
	logic [34:0] kprod;
	logic [34:0] kres;
	logic [30:0] tq;
	always_comb begin
		k     = 4'(cmd.step) + 4'd1;
		tprod = 61'(term_q) * 61'(u_q);
		rprod = 63'(x_q) * 63'(RECIP[k]);
		kprod = 35'(est_q) * 35'(k);
		kres  = 35'(x_q) - kprod;
		tq    = (kres >= 35'(k)) ? est_q + 31'd1 : est_q;
	end

	// final shift of the power of two into Q.F, rounding half up
	logic signed [8:0] sh_s;
	logic [6:0]        sh_r;
	logic [40:0]       ev;
	always_comb begin
		sh_s = 9'($signed(t_q[53:46])) - 9'sd14;
		sh_r = 7'(-sh_s);
		if (!sh_s[8] && sh_s >= 9'sd2) begin
			ev = '1;
		end else if (!sh_s[8]) begin
			ev = sh_s[0] ? 41'({sum_q, 1'b0}) : 41'(sum_q);
		end else if (sh_r >= 7'd40) begin
			ev = '0;
		end else begin
			ev = (41'(sum_q) + (41'd1 << (sh_r - 7'd1))) >> sh_r;
		end
	end

	// log2 normalization
	logic [4:0]  e_n;
	logic [30:0] m_n;
	logic [61:0] msq;
	logic [31:0] mm;
	logic signed [28:0] lq;
	always_comb begin
		e_n = '0;
		for (int i = 1; i < 32; i++) begin
			if (mean_q[i]) e_n = 5'(i);
		end
		if (e_n <= 5'd30) m_n = 31'(mean_q << (5'd30 - e_n));
		else              m_n = mean_q[31:1];
		msq = 62'(m_q) * 62'(m_q);
		mm  = msq[61:30];
		lq  = {~e_q[4], e_q[3:0], frac_q[29:6]};
	end

	// divider step
	logic [32:0] dsh;
	logic        dge;
	always_comb begin
		dsh = {rem_q, dvd_q[63]};
		dge = dsh >= 33'(dvs_q);
	end

	// working response and residual
	logic signed [22:0] lnm;
	logic [40:0]        qcap;
	logic signed [43:0] zw;
	logic [31:0]        cval;
	always_comb begin
		lnm  = lp_q[60:38];
		qcap = (dvd_q > 64'h100_0000_0000) ? 41'h100_0000_0000 : dvd_q[40:0];
		zw   = 44'(lnm) - 44'(item_q.offset) + $signed({3'b0, qcap})
			- 44'sd65536;
		cval = {item_q.count, 16'b0};
	end

	logic [64:0] rsum_add;
	assign rsum_add = {1'b0, rsum_q} + {1'b0, dvd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= '0;
			rank_q  <= '0;
			start_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_MODEL_RANK)      rank_q  <= cfg_data[2:0];
			else if (cfg_index == REG_START_MODE) start_q <= cfg_data[0];
			else                                  coef_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsum_q    <= '0;
			obs_cnt_q <= '0;
		end else if (cmd.op == OP_ACC) begin
			rsum_q <= rsum_add[64] ? '1 : rsum_add[63:0];
			if (obs_cnt_q < CNT_W'(MAX_OBS)) obs_cnt_q <= obs_cnt_q + 1'b1;
		end else if (cmd.op == OP_OUT && item_q.last_obs) begin
			rsum_q    <= '0;
			obs_cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				item_q   <= obs_data;
				eta_q    <= 51'(obs_data.offset);
				mean_q   <= (obs_data.count == 16'd0) ? ZERO_MEAN
					: {obs_data.count, 16'b0};
				mst_q    <= ST_OK;
				disp_q   <= '0;
				disp_v_q <= 1'b0;
			end
			OP_DOT:   eta_q <= eta_next;
			OP_EXP_T: t_q <= 54'(eta_c * $signed({1'b0, LOG2E_Q30}));
			OP_EXP_U: begin
				u_q    <= 30'((60'(t_q[45:16]) * 60'(LN2_Q30)) >> 30);
				term_q <= ONE_Q30;
				sum_q  <= 32'(ONE_Q30);
			end
			OP_TAY_MUL: x_q <= tprod[60:30];
			OP_TAY_EST: est_q <= rprod[62:32];
			OP_TAY_FIX: begin
				term_q <= tq;
				sum_q  <= sum_q + 32'(tq);
			end
			OP_EXP_FIN: begin
				if (ev[40:32] != '0) begin
					mean_q <= '1;
					mst_q  <= ST_SAT_HIGH;
				end else if (ev == '0) begin
					mean_q <= 32'd1;
					mst_q  <= ST_CLAMP_LOW;
				end else begin
					mean_q <= ev[31:0];
				end
			end
			OP_LOG_NORM: begin
				e_q    <= e_n;
				m_q    <= m_n;
				frac_q <= '0;
			end
			OP_LOG_SQ: begin
				if (mm[31]) begin
					m_q <= mm[31:1];
					frac_q[5'd29 - cmd.step[4:0]] <= 1'b1;
				end else begin
					m_q <= mm[30:0];
				end
			end
			OP_LOG_MUL: lp_q <= lq * $signed({1'b0, LN2_Q30});
			OP_DIVQ_INIT: begin
				rem_q <= '0;
				dvd_q <= {16'b0, item_q.count, 32'b0};
				dvs_q <= mean_q;
			end
			OP_DIV_STEP: begin
				rem_q <= dge ? 32'(dsh - 33'(dvs_q)) : dsh[31:0];
				dvd_q <= {dvd_q[62:0], dge};
			end
			OP_RESP: begin
				if (zw > 44'sd2147483647)       z_q <= 32'sh7FFF_FFFF;
				else if (zw < -44'sd2147483648) z_q <= 32'sh8000_0000;
				else                            z_q <= 32'(zw);
				d_q <= (cval > mean_q) ? cval - mean_q : mean_q - cval;
			end
			OP_PSQ: begin
				rem_q <= '0;
				dvd_q <= 64'(d_q) * 64'(d_q);
				dvs_q <= mean_q;
			end
			OP_DIVD_INIT: begin
				rem_q <= '0;
				dvd_q <= rsum_q;
				dvs_q <= 32'(obs_cnt_q - CNT_W'(rank_q));
			end
			OP_DISP: begin
				disp_q   <= (dvd_q[63:48] != '0) ? '1 : dvd_q[47:0];
				disp_v_q <= 1'b1;
			end
			OP_OUT: begin
				res_q.mean             <= mean_q;
				res_q.working_response <= z_q;
				res_q.dispersion       <= disp_q;
				res_q.dispersion_valid <= disp_v_q;
				res_q.status           <= (item_q.last_obs && few) ? ST_FEW_ITEMS : mst_q;
				res_q.last_result      <= item_q.last_obs;
			end
			default: ;
		endcase
	end

	assign res_data = res_q;

endmodule

// ===== tb/sv/plirls_irls_checker.sv =====
// ----------------------------------------------------------------------------
// plirls_irls_checker
// Watches the observation, result and register channels of the IRLS step
// core. Predicts each result in Q16.16 and compares it field by field.
// ----------------------------------------------------------------------------
module plirls_irls_checker
	import plirls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        obs_valid,
	input  logic        obs_ready,
	input  obs_item_t   obs_data,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_item_t   res_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          waiting,
	output int          n_results,
	output int          n_disp
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [31:0] coef_r [NUM_COEF];
	logic [2:0]         rank_r;
	logic               start_r;
	logic [63:0]        pearson_sum;
	int                 obs_seen;
	res_item_t          expected_res [$];

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return (p[127:64] != 0) ? '1 : p[63:0];
	endfunction

	// exp of a Q16.16 exponent via 2^n * 2^f, the fraction by Taylor series in Q30
	function automatic logic [31:0] exp_q16(input longint eta, output logic [1:0] st);
		longint      lim, t, n, s;
		logic [63:0] f30, u, term, sum, val;
		int          r;
		lim = longint'(32) << FRAC_BITS;
		if (eta > lim) eta = lim;
		if (eta < -lim) eta = -lim;
		t = eta * longint'(LOG2E_Q30);
		n = t >>> (FRAC_BITS + 30);
		f30 = (64'(t) & ((64'd1 << (FRAC_BITS + 30)) - 64'd1)) >> FRAC_BITS;
		u = (f30 * 64'(LN2_Q30)) >> 30;
		sum = 64'(ONE_Q30);
		term = 64'(ONE_Q30);
		for (int k = 1; k <= TAYLOR_TERMS; k++) begin
			term = ((term * u) >> 30) / 64'(k);
			sum += term;
		end
		s = n + FRAC_BITS - 30;
		if (s >= 0) begin
			val = (s >= 2) ? '1 : sum << s;
		end else begin
			r = int'(-s);
			val = (r >= 40) ? 64'd0 : (sum + (64'd1 << (r - 1))) >> r;
		end
		st = ST_OK;
		if (val > 64'hFFFF_FFFF) begin
			st = ST_SAT_HIGH;
			return '1;
		end
		if (val == 0) begin
			st = ST_CLAMP_LOW;
			return 32'd1;
		end
		return val[31:0];
	endfunction

	// natural log of a Q16.16 mean: log2 by repeated squaring, then scale by ln2
	function automatic longint ln_q16(logic [31:0] mv);
		int          e;
		logic [63:0] m, frac;
		longint      l;
		e = 31;
		while (e > 0 && !mv[e]) e--;
		m = (e <= 30) ? (64'(mv) << (30 - e)) : (64'(mv) >> 1);
		frac = 0;
		for (int i = 1; i <= LOG_ITERS; i++) begin
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				m >>= 1;
				frac |= 64'd1 << (30 - i);
			end
		end
		l = longint'(e - FRAC_BITS) * longint'(ONE_Q30) + longint'(frac);
		l = l >>> 6;
		return (l * longint'(LN2_Q30)) >>> (54 - FRAC_BITS);
	endfunction

	// one IRLS step: mean, working response, Pearson term and dispersion
	function automatic res_item_t irls_step(obs_item_t it);
		res_item_t          r;
		logic [63:0]        cnt, q, c, d, a, b, term;
		longint             off, eta, lnm, z;
		logic signed [31:0] xs [NUM_COEF];
		logic [31:0]        mean;
		logic [1:0]         st;
		xs = '{it.x_0, it.x_1, it.x_2, it.x_3, it.x_4, it.x_5};
		cnt = 64'(it.count);
		off = longint'(it.offset);
		st = ST_OK;
		if (start_r) begin
			mean = (cnt == 0) ? ZERO_MEAN : 32'(cnt << FRAC_BITS);
		end else begin
			eta = 0;
			for (int i = 0; i < NUM_COEF; i++)
				eta += (longint'(xs[i]) * longint'(coef_r[i])) >>> FRAC_BITS;
			eta += off;
			mean = exp_q16(eta, st);
		end
		lnm = ln_q16(mean);
		q = (cnt << (2 * FRAC_BITS)) / 64'(mean);
		if (q > (64'd1 << 40)) q = 64'd1 << 40;
		z = lnm - off + longint'(q) - (longint'(1) << FRAC_BITS);
		if (z > 64'sd2147483647) z = 64'sd2147483647;
		if (z < -64'sd2147483648) z = -64'sd2147483648;

		c = cnt << FRAC_BITS;
		d = (c > 64'(mean)) ? c - 64'(mean) : 64'(mean) - c;
		a = d / 64'(mean);
		b = d % 64'(mean);
		term = add_sat(add_sat(mul_sat(a, d), mul_sat(a, b)), (b * b) / 64'(mean));
		pearson_sum = add_sat(pearson_sum, term);
		if (obs_seen < MAX_OBS) obs_seen++;

		r.mean = mean;
		r.working_response = 32'(z);
		r.dispersion = '0;
		r.dispersion_valid = 1'b0;
		r.last_result = it.last_obs;
		if (it.last_obs) begin
			if (obs_seen <= int'(rank_r)) begin
				st = ST_FEW_ITEMS;
			end else begin
				q = pearson_sum / 64'(obs_seen - int'(rank_r));
				r.dispersion = (q > 64'hFFFF_FFFF_FFFF) ? '1 : q[47:0];
				r.dispersion_valid = 1'b1;
			end
			pearson_sum = 0;
			obs_seen = 0;
		end
		r.status = st;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("%0t checker: %s mismatch, got 0x%0h, want 0x%0h", $time, field, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			foreach (coef_r[i]) coef_r[i] = '0;
			rank_r = '0;
			start_r = 1'b0;
			pearson_sum = '0;
			obs_seen = 0;
			expected_res.delete();
			errors = 0;
			n_results = 0;
			n_disp = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_res.size() == 0) begin
					$display("%0t checker: result transfer with nothing expected", $time);
					errors++;
				end else begin
					want = expected_res.pop_front();
					n_results++;
					if (res_data.dispersion_valid) n_disp++;
					if (res_data.mean !== want.mean)
						report_mismatch("mean", res_data.mean, want.mean);
					if (res_data.working_response !== want.working_response)
						report_mismatch("working_response", res_data.working_response,
							want.working_response);
					if (res_data.dispersion !== want.dispersion)
						report_mismatch("dispersion", res_data.dispersion, want.dispersion);
					if (res_data.dispersion_valid !== want.dispersion_valid)
						report_mismatch("dispersion_valid", res_data.dispersion_valid,
							want.dispersion_valid);
					if (res_data.status !== want.status)
						report_mismatch("status", res_data.status, want.status);
					if (res_data.last_result !== want.last_result)
						report_mismatch("last_result", res_data.last_result, want.last_result);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MODEL_RANK) rank_r = cfg_data[2:0];
				else if (cfg_index == REG_START_MODE) start_r = cfg_data[0];
				else coef_r[cfg_index] = cfg_data;
			end
			if (obs_valid && obs_ready)
				expected_res.push_back(irls_step(obs_data));
		end
		waiting = expected_res.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the IRLS step core with directed and random observation passes in
// start and fitted mode over several register settings, with random idling
// on both sides; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top
	import plirls_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   errors, waiting, n_results, n_disp;
	int   n_sent;
	bit   rx_hold_req;   // ask the result side for one long hold-off
	bit   quiet;         // no idling on either side
	int   pass_left;     // observations left in the current pass

	plirls_obs_if u_obs ();
	plirls_res_if u_res ();
	plirls_cfg_if u_cfg ();

	poisson_log_link_irls_step_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.obs    (u_obs.sink),
		.res    (u_res.source),
		.cfg    (u_cfg.sink)
	);

	plirls_irls_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.obs_valid (u_obs.valid),
		.obs_ready (u_obs.ready),
		.obs_data  (u_obs.data),
		.res_valid (u_res.valid),
		.res_ready (u_res.ready),
		.res_data  (u_res.data),
		.cfg_valid (u_cfg.valid),
		.cfg_ready (u_cfg.ready),
		.cfg_index (u_cfg.index),
		.cfg_data  (u_cfg.data),
		.errors    (errors),
		.waiting   (waiting),
		.n_results (n_results),
		.n_disp    (n_disp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop; generous against ~1800 observations plus stalls
	initial begin
		#60ms;
		$display("tb_top: done, errors");
		$finish;
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		u_res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				u_res.ready <= 1'b0;
				repeat (900) @(negedge clk);
				rx_hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				u_res.ready <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				u_res.ready <= 1'b1;
			end
		end
	end

	// random 32-bit field: mostly small Q16.16 values, some raw words and extremes
	function automatic logic [31:0] pick_word(int span);
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return 32'($urandom_range(0, 2 * span)) - 32'(span);
		endcase
	endfunction

	function automatic logic [15:0] pick_count();
		case ($urandom_range(0, 9))
			0, 1: return 16'($urandom);
			2, 3: return 16'($urandom_range(0, 1000));
			4: return 16'hFFFF;
			default: return 16'($urandom_range(0, 40));
		endcase
	endfunction

	// random observation; last_obs follows the current pass length
	function automatic obs_item_t rand_obs(bit force_last);
		obs_item_t it;
		it.x_0 = pick_word(4 << FRAC_BITS);
		it.x_1 = pick_word(4 << FRAC_BITS);
		it.x_2 = pick_word(4 << FRAC_BITS);
		it.x_3 = pick_word(4 << FRAC_BITS);
		it.x_4 = pick_word(4 << FRAC_BITS);
		it.x_5 = pick_word(4 << FRAC_BITS);
		it.count = pick_count();
		it.offset = pick_word(2 << FRAC_BITS);
		if (pass_left <= 0)
			pass_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
		pass_left--;
		it.last_obs = force_last || pass_left == 0;
		if (it.last_obs) pass_left = 0;
		return it;
	endfunction

	task automatic put_obs(obs_item_t it);
		int gap;
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			u_obs.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		u_obs.valid <= 1'b1;
		u_obs.data <= it;
		do @(posedge clk); while (!u_obs.ready);
		n_sent++;
	endtask

	// drop valid and wait until every expected result has come back
	task automatic drain();
		@(negedge clk);
		u_obs.valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		u_cfg.valid <= 1'b1;
		u_cfg.index <= idx;
		u_cfg.data <= val;
		do @(posedge clk); while (!u_cfg.ready);
		@(negedge clk);
		u_cfg.valid <= 1'b0;
	endtask

	task automatic write_all(logic [31:0] c0, logic [31:0] step, logic [2:0] rank, bit start);
		for (int i = 0; i < NUM_COEF; i++) write_reg(3'(i), c0 + 32'(i) * step);
		write_reg(REG_MODEL_RANK, 32'(rank));
		write_reg(REG_START_MODE, 32'(start));
	endtask

	task automatic put_fixed(logic [31:0] xv, logic [15:0] cnt, logic [31:0] off, bit last);
		obs_item_t it;
		it = '{xv, xv, xv, xv, xv, xv, cnt, off, last};
		put_obs(it);
	endtask

	initial begin
		obs_item_t it;
		int        n_items;
		u_obs.valid = 1'b0;
		u_obs.data = '0;
		u_cfg.valid = 1'b0;
		u_cfg.index = '0;
		u_cfg.data = '0;
		n_sent = 0;
		pass_left = 0;
		rx_hold_req = 1'b0;
		quiet = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// start mode: zero count takes the small mean, the largest count fits
		write_all(32'd0, 32'd0, 3'd0, 1'b1);
		put_fixed(32'd0, 16'd0, 32'd0, 1'b0);
		put_fixed(32'hFFFF_FFFF, 16'd1, 32'h8000_0000, 1'b0);
		put_fixed(32'h7FFF_FFFF, 16'd2, 32'h7FFF_FFFF, 1'b0);
		put_fixed(32'h8000_0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		put_fixed(32'd0, 16'd5, 32'd0, 1'b1);
		drain();
		// rank 7, above the item count: no dispersion
		write_reg(REG_MODEL_RANK, 32'd7);
		put_fixed(32'd0, 16'd3, 32'd0, 1'b0);
		put_fixed(32'd0, 16'd0, 32'd0, 1'b0);
		put_fixed(32'd0, 16'd9, 32'd0, 1'b1);
		drain();

		// fitted mode, zero coefficients: the offset alone sets the mean
		write_all(32'd0, 32'd0, 3'd6, 1'b0);
		put_fixed(32'h7FFF_FFFF, 16'd1, 32'd0, 1'b0);
		put_fixed(32'h8000_0000, 16'd0, 32'h7FFF_FFFF, 1'b0);     // saturates high
		put_fixed(32'd0, 16'hFFFF, 32'h8000_0000, 1'b0);          // clamps low
		put_fixed(32'd0, 16'd7, 32'h0014_0000, 1'b0);
		put_fixed(32'd0, 16'd3, 32'hFFEC_0000, 1'b0);
		put_fixed(32'd0, 16'd1, 32'h0000_8000, 1'b0);
		put_fixed(32'd0, 16'd2, 32'hFFFF_8000, 1'b1);
		drain();

		// coefficients at their extremes against extreme rows
		write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 3'd1, 1'b0);
		put_fixed(32'h8000_0000, 16'hFFFF, 32'h8000_0000, 1'b0);
		put_fixed(32'h7FFF_FFFF, 16'd0, 32'h7FFF_FFFF, 1'b0);
		put_fixed(32'h0000_0001, 16'd10, 32'd0, 1'b0);
		put_fixed(32'hFFFF_FFFF, 16'd1, 32'hFFFF_FFFF, 1'b1);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 1)
				write_all(32'h8000_0000, 32'h7FFF_FFFF, 3'd0, 1'b0);
			else if (ph == 5)
				write_all($urandom, $urandom, 3'($urandom_range(0, 7)), 1'b0);
			else begin
				for (int i = 0; i < NUM_COEF; i++)
					write_reg(3'(i), ($urandom_range(0, 3) == 0) ? $urandom
						: 32'($urandom_range(0, 65536)) - 32'd32768);
				write_reg(REG_MODEL_RANK, 32'($urandom_range(0, 7)));
				write_reg(REG_START_MODE, 32'(ph % 3 == 0));
			end
			if (ph == 3) rx_hold_req = 1'b1;
			if (ph == 7) quiet = 1'b1;
			n_items = 215;
			for (int k = 0; k < n_items; k++) begin
				it = rand_obs(k == n_items - 1);
				put_obs(it);
			end
			drain();
		end

		// drain() has already waited for every result; allow a margin and report
		repeat (300) @(posedge clk);
		$display("tb_top: %0d observations sent, %0d results checked, %0d with dispersion",
			n_sent, n_results, n_disp);
		$display("tb_top: start and fitted mode, ranks 0 to 7, extreme rows and coefficients");
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
